// ----- hdl/reservoir_sampler_range_query_macros.svh -----
// assertion helpers
`ifndef RESERVOIR_SAMPLER_RANGE_QUERY_MACROS_SVH
`define RESERVOIR_SAMPLER_RANGE_QUERY_MACROS_SVH
`define RSRQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define RSRQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`endif

// ----- hdl/rsrq_pkg.sv -----
// ---------------------------------------------------------------------------
// rsrq_pkg
// Types and constants of the reservoir sampler with range queries.
// ---------------------------------------------------------------------------
`default_nettype none
package rsrq_pkg;
    localparam int DEPTH_DEF = 256;
    localparam int SIZE_W    = 9;

    localparam logic [2:0] FN_INSERT   = 3'd0;
    localparam logic [2:0] FN_CLEAR    = 3'd1;
    localparam logic [2:0] FN_FREQ     = 3'd2;
    localparam logic [2:0] FN_DISTINCT = 3'd3;
    localparam logic [2:0] FN_MEMBER   = 3'd4;
    localparam logic [2:0] FN_L2       = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] key_ip;
        logic [15:0] key_x;
        logic [15:0] key_y;
        logic [31:0] random_draw;
        logic [15:0] rect_x_low;
        logic [15:0] rect_x_high;
        logic [15:0] rect_y_low;
        logic [15:0] rect_y_high;
        logic [31:0] ip_low;
        logic [31:0] ip_high;
    } t_in;

    typedef struct packed {
        logic [31:0] answer;
        logic [31:0] items_seen;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item
        logic div_start; // start modulo
        logic mul_start; // start scaling
        logic ptr_clr;   // i=0
        logic inner_clr; // j=0
        logic rd_i;      // read slot i
        logic rd_j;      // read slot j
        logic eval_i;    // latch slot i
        logic eval_j;    // compare slot j
        logic inc_i;
        logic inc_j;
        logic do_insert;
        logic do_clear;
        logic fin;       // form answer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] func;
        logic       div_done;
        logic       mul_done;
        logic       i_end;
        logic       j_end;
        logic       i_match;  // slot i in rect
        logic       stop_j;   // inner loop may end
        logic       member_hit;
    } t_sts;
endpackage
`default_nettype wire

// ----- hdl/rsrq_ctrl.sv -----
// ---------------------------------------------------------------------------
// rsrq_ctrl
// Sequencer for insert, clear and the scanning queries.
// ---------------------------------------------------------------------------
`default_nettype none
module rsrq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire rsrq_pkg::t_sts  i_sts,
    output rsrq_pkg::t_cmd       o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_RDI   = 11'b00000001000,
        S_EVI   = 11'b00000010000,
        S_RDJ   = 11'b00000100000,
        S_EVJ   = 11'b00001000000,
        S_MUL   = 11'b00010000000,
        S_FIN   = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_NEXTI = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    wire logic accept = i_valid && !o_stall;
    wire logic take   = r_ovalid && !i_stall;
    wire logic scaled_fn = (i_sts.func == rsrq_pkg::FN_FREQ) ||
                           (i_sts.func == rsrq_pkg::FN_DISTINCT);
    wire logic inner_fn  = (i_sts.func == rsrq_pkg::FN_DISTINCT) ||
                           (i_sts.func == rsrq_pkg::FN_L2);

    assign o_stall = !(r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !take;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.ptr_clr = 1'b1;
                case (i_sts.func)
                    rsrq_pkg::FN_INSERT: begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end
                    rsrq_pkg::FN_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state = S_FIN;
                    end
                    rsrq_pkg::FN_FREQ, rsrq_pkg::FN_DISTINCT,
                    rsrq_pkg::FN_MEMBER, rsrq_pkg::FN_L2: n_state = S_RDI;
                    default: n_state = S_FIN;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.do_insert = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_RDI: begin
                if (i_sts.i_end || i_sts.member_hit) begin
                    if (scaled_fn) begin
                        o_cmd.mul_start = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state = S_EVI;
                end
            end
            S_EVI: begin
                o_cmd.eval_i = 1'b1;
                o_cmd.inner_clr = 1'b1;
                n_state = S_NEXTI;
            end
            S_NEXTI: begin
                if (inner_fn && i_sts.i_match) begin
                    n_state = S_RDJ;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state = S_RDI;
                end
            end
            S_RDJ: begin
                if (i_sts.stop_j) begin
                    o_cmd.inc_i = 1'b1;
                    n_state = S_RDI;
                end else begin
                    o_cmd.rd_j = 1'b1;
                    n_state = S_EVJ;
                end
            end
            S_EVJ: begin
                o_cmd.eval_j = 1'b1;
                o_cmd.inc_j = 1'b1;
                n_state = S_RDJ;
            end
            S_MUL: begin
                if (i_sts.mul_done) n_state = S_FIN;
            end
            S_FIN: begin
                // hold the result register until the previous beat is taken
                if (!r_ovalid) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/rsrq_dp.sv -----
// ---------------------------------------------------------------------------
// rsrq_dp
// Reservoir memory, counters, serial modulo and serial scaling.
// ---------------------------------------------------------------------------
`default_nettype none
module rsrq_dp #(
    parameter int DEPTH = rsrq_pkg::DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [8:0]            i_cfg_data,
    input  wire rsrq_pkg::t_in         i_item,
    input  wire rsrq_pkg::t_cmd        i_cmd,
    output rsrq_pkg::t_sts             o_sts,
    output rsrq_pkg::t_out             o_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [63:0] mem [DEPTH];

    rsrq_pkg::t_in r_item;
    logic [8:0]    r_size;
    logic [31:0]   r_seen;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_i, r_j;
    logic [63:0]   r_rd;
    logic [31:0]   r_ip_i;
    logic          r_match_i;
    logic          r_fresh;
    logic [31:0]   r_cnt;
    logic [31:0]   r_ans;
    logic [31:0]   r_out_seen;

    // effective size
    logic [CW-1:0] eff;
    always_comb begin
        if (r_size == 9'd0) eff = CW'(1);
        else if ({23'd0, r_size} > DEPTH) eff = CW'(DEPTH);
        else eff = CW'(r_size);
    end

    wire logic [15:0] rx = r_rd[31:16];
    wire logic [15:0] ry = r_rd[15:0];
    wire logic [31:0] rip = r_rd[63:32];
    wire logic in_rect = rx >= r_item.rect_x_low && rx <= r_item.rect_x_high &&
                         ry >= r_item.rect_y_low && ry <= r_item.rect_y_high;

    // restoring modulo: draw % (seen+1), one bit per cycle
    logic [32:0] r_rem;
    logic [31:0] r_dvd;
    logic [32:0] r_dvs;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    wire  logic [32:0] rem_sh = {r_rem[31:0], r_dvd[31]};
    wire  logic        rem_ge = rem_sh >= r_dvs;

    // shift-add multiply then restoring divide by eff
    logic [63:0] r_prod;
    logic [63:0] r_mcand;
    logic [31:0] r_mplr;
    logic [6:0]  r_mcnt;
    logic [1:0]  r_mph;   // 0 idle,1 mul,2 div
    logic [63:0] r_q;
    logic [CW:0] r_mrem;
    wire  logic [CW:0] mrem_sh = {r_mrem[CW-1:0], r_prod[63]};
    wire  logic        mrem_ge = mrem_sh >= {1'b0, eff};

    wire logic fill_phase = r_fill < eff;
    wire logic [32:0] slot_r = r_rem;
    wire logic wr_en = i_cmd.do_insert &&
                       (fill_phase || slot_r < 33'(eff));
    wire logic [AW-1:0] wr_addr = fill_phase ? r_fill[AW-1:0] : slot_r[AW-1:0];
    wire logic [AW-1:0] rd_addr = i_cmd.rd_j ? r_j[AW-1:0] : r_i[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= {r_item.key_ip, r_item.key_x, r_item.key_y};
        if (i_cmd.rd_i || i_cmd.rd_j) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 9'd256;
            r_seen  <= '0;
            r_fill  <= '0;
            r_dbusy <= 1'b0;
            r_mph   <= 2'd0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_data;
            if (i_cmd.do_clear) begin
                r_seen <= '0;
                r_fill <= '0;
            end
            if (i_cmd.do_insert) begin
                if (fill_phase) r_fill <= r_fill + CW'(1);
                if (r_seen != 32'hFFFF_FFFF) r_seen <= r_seen + 32'd1;
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= 6'd0;
                r_rem   <= '0;
                r_dvd   <= r_item.random_draw;
                r_dvs   <= {1'b0, r_seen} + 33'd1;
            end else if (r_dbusy) begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_rem <= rem_ge ? rem_sh - r_dvs : rem_sh;
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd31) r_dbusy <= 1'b0;
            end
            if (i_cmd.mul_start) begin
                r_mph   <= 2'd1;
                r_mcnt  <= '0;
                r_prod  <= '0;
                r_mcand <= {32'd0, r_cnt};
                r_mplr  <= r_seen;
            end else if (r_mph == 2'd1) begin
                if (r_mplr[0]) r_prod <= r_prod + r_mcand;
                r_mcand <= {r_mcand[62:0], 1'b0};
                r_mplr  <= {1'b0, r_mplr[31:1]};
                r_mcnt  <= r_mcnt + 7'd1;
                if (r_mcnt == 7'd31) begin
                    r_mph  <= 2'd2;
                    r_mcnt <= '0;
                    r_mrem <= '0;
                end
            end else if (r_mph == 2'd2) begin
                r_prod <= {r_prod[62:0], 1'b0};
                r_mrem <= mrem_ge ? mrem_sh - {1'b0, eff} : mrem_sh;
                r_q    <= {r_q[62:0], mrem_ge};
                r_mcnt <= r_mcnt + 7'd1;
                if (r_mcnt == 7'd63) r_mph <= 2'd0;
            end
        end
    end

    wire logic i_hit_ip = rip >= r_item.ip_low && rip <= r_item.ip_high;
    wire logic memb     = in_rect && rip == r_item.key_ip;
    logic r_memb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.ptr_clr) begin
            r_i    <= '0;
            r_cnt  <= '0;
            r_memb <= 1'b0;
        end
        if (i_cmd.inc_i) r_i <= r_i + CW'(1);
        if (i_cmd.inner_clr) begin
            r_j     <= '0;
            r_fresh <= 1'b1;
        end
        if (i_cmd.inc_j) r_j <= r_j + CW'(1);
        if (i_cmd.eval_i) begin
            r_ip_i    <= rip;
            r_match_i <= in_rect;
            if (r_item.func == rsrq_pkg::FN_FREQ && in_rect && i_hit_ip)
                r_cnt <= r_cnt + 32'd1;
            if (memb) r_memb <= 1'b1;
        end
        if (i_cmd.eval_j && in_rect && rip == r_ip_i) begin
            if (r_item.func == rsrq_pkg::FN_L2) r_cnt <= r_cnt + 32'd1;
            else r_fresh <= 1'b0;
        end
        if (r_item.func == rsrq_pkg::FN_DISTINCT && i_cmd.inc_i && o_sts.stop_j &&
            r_fresh && r_match_i && !i_cmd.eval_i)
            r_cnt <= r_cnt + 32'd1;
        if (i_cmd.fin) begin
            r_out_seen <= r_seen;
            case (r_item.func)
                rsrq_pkg::FN_FREQ, rsrq_pkg::FN_DISTINCT:
                    r_ans <= (r_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_q[31:0];
                rsrq_pkg::FN_MEMBER: r_ans <= {31'd0, r_memb};
                rsrq_pkg::FN_L2:     r_ans <= r_cnt;
                default:             r_ans <= '0;
            endcase
        end
    end

    // distinct: inner j runs to i (stop early when not fresh); l2: j runs to fill
    wire logic [CW-1:0] j_lim = (r_item.func == rsrq_pkg::FN_DISTINCT) ? r_i : r_fill;
    always_comb begin
        o_sts.func       = r_item.func;
        o_sts.div_done   = !r_dbusy && !i_cmd.div_start;
        o_sts.mul_done   = r_mph == 2'd0;
        o_sts.i_end      = r_i >= r_fill;
        o_sts.j_end      = r_j >= j_lim;
        o_sts.i_match    = r_match_i;
        o_sts.stop_j     = (r_j >= j_lim) ||
                           (r_item.func == rsrq_pkg::FN_DISTINCT && !r_fresh);
        o_sts.member_hit = r_item.func == rsrq_pkg::FN_MEMBER && r_memb;
        o_out.answer     = r_ans;
        o_out.items_seen = r_out_seen;
    end
endmodule
`default_nettype wire

// ----- hdl/reservoir_sampler_range_query.sv -----
// ---------------------------------------------------------------------------
// reservoir_sampler_range_query
// Reservoir sample of (ip,x,y) keys with rectangle range queries.
// ---------------------------------------------------------------------------
// Insert: the result beat follows the 32-step serial modulo.
// Frequency: a scan of the filled slots, then serial scaling; membership: the scan stops at the first hit.
// Distinct and L2 square: an inner scan for each matching slot, one memory port.
// One item at a time; stall is high from accept until the result beat is presented.
// Synchronous active-low reset clears the seen and fill counts and sets size to 256; memory is not cleared.
`default_nettype none
module reservoir_sampler_range_query #(
    parameter int DEPTH = rsrq_pkg::DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [8:0]     i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire rsrq_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output rsrq_pkg::t_out      o_data
);
    rsrq_pkg::t_cmd cmd;
    rsrq_pkg::t_sts sts;

    rsrq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(sts), .o_cmd(cmd)
    );

    rsrq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_item(i_data), .i_cmd(cmd),
        .o_sts(sts), .o_out(o_data)
    );
endmodule
`default_nettype wire

// ----- hdl/rsrq_checker.sv -----
// ---------------------------------------------------------------------------
// rsrq_checker
// Port-level checks of the sampler.
// ---------------------------------------------------------------------------
`default_nettype none
`include "reservoir_sampler_range_query_macros.svh"
module rsrq_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_stall,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire rsrq_pkg::t_out o_data
);
    `RSRQ_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `RSRQ_ASSERT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_data))
    `RSRQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)
    `RSRQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)
endmodule
bind reservoir_sampler_range_query rsrq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// Reservoir sampler range query testbench
// Drives insert, clear and query beats through the valid/stall channels and
// compares every result beat against a cycle-free model of the sample store.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int DEPTH = 256;
    localparam int LIMIT = 4000000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [8:0]     i_cfg_data = '0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    rsrq_pkg::t_in  i_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    rsrq_pkg::t_out o_data;

    reservoir_sampler_range_query #(.DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // sample store mirror
    logic [31:0] mir_ip [DEPTH];
    logic [15:0] mir_x  [DEPTH];
    logic [15:0] mir_y  [DEPTH];
    logic [31:0] seen;
    int          filled;
    logic [8:0]  size_reg;

    rsrq_pkg::t_out expected_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          sink_idle_pct = 32;
    int          src_idle_pct = 32;
    bit          sink_hold = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > DEPTH) return DEPTH;
        return size_reg;
    endfunction

    function automatic bit in_rect(int k, rsrq_pkg::t_in b);
        return mir_x[k] >= b.rect_x_low && mir_x[k] <= b.rect_x_high &&
               mir_y[k] >= b.rect_y_low && mir_y[k] <= b.rect_y_high;
    endfunction

    function automatic logic [31:0] scale_count(int c);
        logic [63:0] v;
        v = (64'(c) * 64'(seen)) / 64'(eff_size());
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic rsrq_pkg::t_out sample_step(rsrq_pkg::t_in b);
        rsrq_pkg::t_out r;
        int   c;
        int   slot;
        bit   fresh;
        logic [63:0] m;
        r = '0;
        c = 0;
        case (b.func)
            rsrq_pkg::FN_INSERT: begin
                slot = DEPTH;
                if (filled < eff_size()) begin
                    slot = filled;
                    filled++;
                end else begin
                    m = 64'(b.random_draw) % (64'(seen) + 64'd1);
                    if (m < eff_size()) slot = int'(m);
                end
                if (slot < DEPTH) begin
                    mir_ip[slot] = b.key_ip;
                    mir_x[slot] = b.key_x;
                    mir_y[slot] = b.key_y;
                end
                if (seen != 32'hFFFF_FFFF) seen++;
            end
            rsrq_pkg::FN_CLEAR: begin
                seen = 0;
                filled = 0;
            end
            rsrq_pkg::FN_FREQ: begin
                for (int k = 0; k < filled; k++)
                    if (in_rect(k, b) && mir_ip[k] >= b.ip_low && mir_ip[k] <= b.ip_high) c++;
                r.answer = scale_count(c);
            end
            rsrq_pkg::FN_DISTINCT: begin
                for (int k = 0; k < filled; k++) begin
                    fresh = in_rect(k, b);
                    for (int q = 0; fresh && q < k; q++)
                        if (in_rect(q, b) && mir_ip[q] == mir_ip[k]) fresh = 0;
                    if (fresh) c++;
                end
                r.answer = scale_count(c);
            end
            rsrq_pkg::FN_MEMBER: begin
                for (int k = 0; k < filled; k++)
                    if (mir_ip[k] == b.key_ip && in_rect(k, b)) r.answer = 1;
            end
            rsrq_pkg::FN_L2: begin
                for (int k = 0; k < filled; k++) begin
                    if (!in_rect(k, b)) continue;
                    for (int q = 0; q < filled; q++)
                        if (mir_ip[q] == mir_ip[k] && in_rect(q, b)) c++;
                end
                r.answer = 32'(c);
            end
            default: ;
        endcase
        r.items_seen = seen;
        return r;
    endfunction

    // result checker and sink stall
    always @(posedge i_clk) begin
        rsrq_pkg::t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time, o_data);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_data.answer !== e.answer) begin
                    $display("%0t answer mismatch: expected %h actual %h",
                             $time, e.answer, o_data.answer);
                    errors++;
                end
                if (o_data.items_seen !== e.items_seen) begin
                    $display("%0t items_seen mismatch: expected %h actual %h",
                             $time, e.items_seen, o_data.items_seen);
                    errors++;
                end
            end
        end
        i_stall <= sink_hold || ($urandom_range(99) < sink_idle_pct);
    end

    // valid stays high after the beat; drain, or an idle draw in the next send, drops it
    task automatic send_beat(rsrq_pkg::t_in b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q = {expected_q, sample_step(b)};
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_size(logic [8:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = v;
    endtask

    function automatic rsrq_pkg::t_in full_rect(logic [2:0] f);
        rsrq_pkg::t_in b;
        b = '0;
        b.func = f;
        b.rect_x_high = 16'hFFFF;
        b.rect_y_high = 16'hFFFF;
        b.ip_high = 32'hFFFF_FFFF;
        return b;
    endfunction

    // narrow beats draw keys from a small pool so queries see repeats
    function automatic rsrq_pkg::t_in rand_beat(bit wide);
        rsrq_pkg::t_in b;
        b = '0;
        b.func = (wide && $urandom_range(19) == 0) ? 3'($urandom_range(7))
               : ($urandom_range(1) ? rsrq_pkg::FN_INSERT : 3'(2 + $urandom_range(3)));
        if ($urandom_range(50) == 0) b.func = rsrq_pkg::FN_CLEAR;
        b.key_ip = wide ? $urandom() : $urandom_range(5);
        b.key_x = wide ? 16'($urandom()) : 16'($urandom_range(15));
        b.key_y = wide ? 16'($urandom()) : 16'($urandom_range(15));
        b.random_draw = $urandom();
        b.rect_x_low = wide ? 16'($urandom()) : 16'($urandom_range(8));
        b.rect_x_high = wide ? 16'($urandom()) : 16'($urandom_range(6, 15));
        b.rect_y_low = wide ? 16'($urandom()) : 16'($urandom_range(8));
        b.rect_y_high = wide ? 16'($urandom()) : 16'($urandom_range(6, 15));
        b.ip_low = wide ? $urandom() : $urandom_range(3);
        b.ip_high = wide ? $urandom() : $urandom_range(2, 5);
        return b;
    endfunction

    task automatic test_directed();
        rsrq_pkg::t_in b;
        write_size(9'd4);
        for (int k = 0; k < 6; k++) begin
            b = full_rect(rsrq_pkg::FN_INSERT);
            b.key_ip = (k == 0) ? 32'hFFFF_FFFF : 32'(k % 2);
            b.key_x = (k == 1) ? 16'hFFFF : 16'(k);
            b.key_y = (k == 2) ? 16'hFFFF : 16'(k);
            b.random_draw = (k == 5) ? 32'hFFFF_FFFF : 32'(k);
            send_beat(b);
        end
        for (int f = rsrq_pkg::FN_FREQ; f <= 7; f++) send_beat(full_rect(3'(f)));
        b = full_rect(rsrq_pkg::FN_MEMBER);
        b.key_ip = 32'hFFFF_FFFF;
        send_beat(b);
        b = full_rect(rsrq_pkg::FN_FREQ);
        b.rect_x_low = 16'd5;
        b.rect_x_high = 16'd1;
        send_beat(b);
        b = full_rect(rsrq_pkg::FN_FREQ);
        b.ip_low = 32'd9;
        b.ip_high = 32'd2;
        send_beat(b);
        write_size(9'd2);
        b = full_rect(rsrq_pkg::FN_INSERT);
        b.random_draw = 32'd6;
        send_beat(b);
        send_beat(full_rect(rsrq_pkg::FN_L2));
        write_size(9'd0);
        send_beat(full_rect(rsrq_pkg::FN_DISTINCT));
        send_beat(full_rect(rsrq_pkg::FN_CLEAR));
        send_beat(full_rect(rsrq_pkg::FN_FREQ));
    endtask

    task automatic test_random(int n, logic [8:0] sz);
        write_size(sz);
        for (int k = 0; k < n; k++) send_beat(rand_beat($urandom_range(9) == 0));
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_beat(rand_beat(1'b0));
        join
        drain();
        src_idle_pct = 32;
    endtask

    task automatic test_no_idle(int n);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        for (int k = 0; k < n; k++) send_beat(rand_beat(1'b0));
        src_idle_pct = 32;
        sink_idle_pct = 32;
    endtask

    initial begin
        seen = 0;
        filled = 0;
        size_reg = 9'd256;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(20, 9'd8);
        test_backpressure();
        test_no_idle(15);
        test_random(15, 9'd256);
        test_random(15, 9'd300);
        test_random(10, 9'd1);
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
